// File: rtl/core/mf3_pkg.sv
// Shared types, widths and register map of the 3x3 median filter.
package mf3_pkg;

	localparam int PIX_W  = 8;
	localparam int OCOL_W = 11;
	localparam int OROW_W = 12;
	localparam int FW_W   = 12;
	localparam int FH_W   = 13;

	typedef logic [PIX_W-1:0]  pixel_t;
	typedef logic [OCOL_W-1:0] ocol_t;
	typedef logic [OROW_W-1:0] orow_t;
	typedef logic [FW_W-1:0]   fw_t;
	typedef logic [FH_W-1:0]   fh_t;

	// Frame size limits and register reset values
	localparam int  MIN_DIM      = 3;
	localparam int  HEIGHT_LIMIT = 4096;
	localparam fw_t FW_RESET     = 12'd640;
	localparam fh_t FH_RESET     = 13'd480;

	// Configuration port
	localparam int   APB_ADDR_W       = 3;
	localparam int   APB_DATA_W       = 32;
	localparam int   REG_SEL_BIT      = 2;
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

endpackage

// File: rtl/core/mf3_if.sv
// Pixel and result stream interfaces of the 3x3 median filter.
interface mf3_pixel_if import mf3_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface mf3_result_if import mf3_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t median;
	ocol_t  out_column;
	orow_t  out_row;
	logic   frame_last;

	modport source (output valid, output median, output out_column, output out_row,
		output frame_last, input ready);
	modport sink (input valid, input median, input out_column, input out_row,
		input frame_last, output ready);
endinterface

// File: rtl/core/median_filter_3x3.sv
// 3x3 median filter over a raster-order 8-bit grayscale pixel stream.
//
// Usage:
//   pix  : valid/ready stream of pixels, row-major, one item per pixel.
//   res  : valid/ready stream of results, one item per interior position,
//          carrying the median, its column and row, and frame_last on the
//          last result of a frame. Border positions give no item.
//   APB  : frame_width at address 0, frame_height at address 4. Write them
//          only while the filter is idle.
// Timing:
//   An accepted pixel passes stage 1, the stage 2 window and the output
//   register. One pixel per cycle is sustained unless res.ready stalls;
//   the line store is a single memory with one read and one write port,
//   read on accept and written back as stage 1 advances, setting that rate.
// Reset:
//   arst_n clears the pipeline and the position counters and loads the
//   default 640x480 frame size. The line store needs no clearing: its
//   contents are only used after the two rows above have been written.
// Stall:
//   Each stage holds its item while the next one is full; the input keeps
//   accepting pixels until all three stages are occupied.
module median_filter_3x3 import mf3_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	mf3_pixel_if.sink             pix,
	mf3_result_if.source          res
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WCW = (CW + 1 > FH_W) ? CW + 1 : FH_W;

	typedef logic [CW-1:0]  col_t;
	typedef logic [WCW-1:0] wcmp_t;

	// Small compare helpers for the median network
	function automatic pixel_t min2(input pixel_t a, input pixel_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pixel_t max2(input pixel_t a, input pixel_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// Configuration registers
	fw_t frame_width_q;
	fh_t frame_height_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else if (cfg_wr) begin
			case (paddr[REG_SEL_BIT])
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[REG_SEL_BIT])
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	// Handshake chain
	logic valid_s1, valid_s2, out_valid_q;
	logic ready_s1, ready_s2, ready_o;
	logic in_acc, adv_s1;

	assign ready_o  = !out_valid_q || res.ready;
	assign ready_s2 = !valid_s2 || ready_o;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign pix.ready = ready_s1;
	assign in_acc   = pix.valid && ready_s1;
	assign adv_s1   = valid_s1 && ready_s2;

	// Clamp frame size and find the last column and row
	col_t  col_q;
	orow_t row_q;
	wcmp_t fw_ext, eff_w;
	fh_t   eff_h;
	logic  last_col, last_row;

	assign fw_ext = wcmp_t'(frame_width_q);

	always_comb begin
		if (fw_ext < wcmp_t'(MIN_DIM)) begin
			eff_w = wcmp_t'(MIN_DIM);
		end else if (fw_ext > wcmp_t'(MAX_WIDTH)) begin
			eff_w = wcmp_t'(MAX_WIDTH);
		end else begin
			eff_w = fw_ext;
		end
		if (frame_height_q < fh_t'(MIN_DIM)) begin
			eff_h = fh_t'(MIN_DIM);
		end else if (frame_height_q > fh_t'(HEIGHT_LIMIT)) begin
			eff_h = fh_t'(HEIGHT_LIMIT);
		end else begin
			eff_h = frame_height_q;
		end
	end

	assign last_col = wcmp_t'(col_q) >= (eff_w - wcmp_t'(1));
	assign last_row = {1'b0, row_q} >= (eff_h - fh_t'(1));

	// Advance the raster position on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + orow_t'(1);
			end else begin
				col_q <= col_q + col_t'(1);
			end
		end
	end

	// Stage 1: capture pixel and position
	pixel_t pixel_s1;
	col_t   col_s1;
	logic   emit_s1, last_s1;
	ocol_t  ocol_s1;
	orow_t  orow_s1;
	col_t   col_m1;

	assign col_m1 = col_q - col_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_s1 <= pix.pixel;
			col_s1   <= col_q;
			emit_s1  <= (wcmp_t'(col_q) >= wcmp_t'(2)) && (row_q >= orow_t'(2));
			ocol_s1  <= ocol_t'(col_m1);
			orow_s1  <= row_q - orow_t'(1);
			last_s1  <= last_col && last_row;
		end
	end

	// Line store: upper byte is two rows above, lower byte one row above
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] ls_rd_q;
	pixel_t top_s1, mid_s1;

	assign top_s1 = ls_rd_q[2*PIX_W-1:PIX_W];
	assign mid_s1 = ls_rd_q[PIX_W-1:0];

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ls_rd_q <= line_mem[col_q];
		end
		if (adv_s1) begin
			line_mem[col_s1] <= {mid_s1, pixel_s1};
		end
	end

	// Sort the incoming column
	pixel_t l1, h1, t1, col_lo, col_md, col_hi;

	always_comb begin
		l1     = min2(top_s1, mid_s1);
		h1     = max2(top_s1, mid_s1);
		col_lo = min2(l1, pixel_s1);
		t1     = max2(l1, pixel_s1);
		col_md = min2(h1, t1);
		col_hi = max2(h1, t1);
	end

	// Stage 2: window of three sorted columns
	pixel_t win_lo_s2 [3];
	pixel_t win_md_s2 [3];
	pixel_t win_hi_s2 [3];
	logic   emit_s2, last_s2;
	ocol_t  ocol_s2;
	orow_t  orow_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			win_lo_s2[0] <= win_lo_s2[1];
			win_lo_s2[1] <= win_lo_s2[2];
			win_lo_s2[2] <= col_lo;
			win_md_s2[0] <= win_md_s2[1];
			win_md_s2[1] <= win_md_s2[2];
			win_md_s2[2] <= col_md;
			win_hi_s2[0] <= win_hi_s2[1];
			win_hi_s2[1] <= win_hi_s2[2];
			win_hi_s2[2] <= col_hi;
			emit_s2      <= emit_s1;
			last_s2      <= last_s1;
			ocol_s2      <= ocol_s1;
			orow_s2      <= orow_s1;
		end
	end

	// Median of nine from sorted columns
	pixel_t lo_max, md_med, hi_min, med9;

	always_comb begin
		lo_max = max2(max2(win_lo_s2[0], win_lo_s2[1]), win_lo_s2[2]);
		md_med = med3(win_md_s2[0], win_md_s2[1], win_md_s2[2]);
		hi_min = min2(min2(win_hi_s2[0], win_hi_s2[1]), win_hi_s2[2]);
		med9   = med3(lo_max, md_med, hi_min);
	end

	// Output register: drop border items
	pixel_t median_q;
	ocol_t  ocol_q;
	orow_t  orow_q;
	logic   last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_o) begin
			out_valid_q <= valid_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_s2 && emit_s2) begin
			median_q <= med9;
			ocol_q   <= ocol_s2;
			orow_q   <= orow_s2;
			last_q   <= last_s2;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.median     = median_q;
	assign res.out_column = ocol_q;
	assign res.out_row    = orow_q;
	assign res.frame_last = last_q;

	// Line store read and write-back never hit the same entry in one cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && adv_s1) |-> (col_q != col_s1))
		else $error("line store read and write at the same column");

	// A result always lies below the first row
	a_interior_row: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.out_row != '0))
		else $error("result on the top border row");

endmodule

// File: verif/median_filter_3x3_tb.sv
// Self-checking testbench for the 3x3 median filter: random frames, sizes and handshake gaps.
`timescale 1ns / 100ps

module median_filter_3x3_tb import mf3_pkg::*; ();

	localparam int          LINE_MAX     = 2048;
	localparam int unsigned FILL_WIDTH   = 72;
	localparam int unsigned RANDOM_ITEMS = 1100;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned QUIET_LIMIT  = 5000;
	localparam int unsigned REPORT_CAP   = 30;

	// Pixel patterns for queued stimulus
	localparam int unsigned STYLE_UNIFORM   = 0;
	localparam int unsigned STYLE_BAND      = 1;
	localparam int unsigned STYLE_EXTREMES  = 2;

	// Hand-picked frames: a 5x4 frame of mostly extremes and a lone 3x3 window
	localparam logic [0:19][7:0] CORNER_FRAME = {
		8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
		8'd255, 8'd0,   8'd255, 8'd0,   8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd0,   8'd0,   8'd0,   8'd128, 8'd1
	};
	localparam logic [0:8][7:0] LONE_WINDOW = {
		8'd200, 8'd17, 8'd99, 8'd4, 8'd250, 8'd63, 8'd128, 8'd31, 8'd180
	};

	typedef struct packed {
		pixel_t median;
		ocol_t  column;
		orow_t  row;
		logic   last;
	} filter_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;

	mf3_pixel_if  pix_bus ();
	mf3_result_if res_bus ();

	median_filter_3x3 #(.MAX_WIDTH(LINE_MAX)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix     (pix_bus),
		.res     (res_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirror of the filter: registers, line stores, window and position
	fw_t         frame_width_reg;
	fh_t         frame_height_reg;
	pixel_t      row_above [LINE_MAX];
	pixel_t      row_two_above [LINE_MAX];
	pixel_t      nbhd [9];
	int unsigned col_pos, row_pos;

	filter_result_t expected_medians [$];
	pixel_t         pixels_to_send [$];

	int unsigned pixels_queued = 0, pixels_accepted = 0;
	int unsigned results_checked = 0, frames_closed = 0, reg_writes = 0;
	int unsigned failures = 0;
	int unsigned gap_left = 0, stall_left = 0, quiet_cycles = 0;
	bit          src_calm = 1'b0, sink_calm = 1'b0;
	filter_result_t want_result, got_result;

	function automatic int unsigned active_width();
		if (frame_width_reg < MIN_DIM) return MIN_DIM;
		if (frame_width_reg > LINE_MAX) return LINE_MAX;
		return frame_width_reg;
	endfunction

	function automatic int unsigned active_height();
		if (frame_height_reg < MIN_DIM) return MIN_DIM;
		if (frame_height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
		return frame_height_reg;
	endfunction

	// Sort a copy of the window and take the middle value
	function automatic pixel_t window_median();
		pixel_t sorted [9];
		pixel_t held;
		int     j;
		sorted = nbhd;
		for (int i = 1; i < 9; i++) begin
			held = sorted[i];
			j = i;
			while (j > 0 && sorted[j-1] > held) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = held;
		end
		return sorted[4];
	endfunction

	// Advance the mirror by one pixel and queue the result it completes
	task automatic slide_window(pixel_t px);
		int unsigned    w, h, c, r;
		pixel_t         upper, middle;
		bit             end_col, end_row;
		filter_result_t made;
		w = active_width();
		h = active_height();
		c = col_pos;
		r = row_pos;
		end_col = (c >= w - 1);
		end_row = (r >= h - 1);
		upper = row_two_above[c];
		middle = row_above[c];
		row_two_above[c] = middle;
		row_above[c] = px;
		for (int k = 0; k < 9; k += 3) begin
			nbhd[k] = nbhd[k+1];
			nbhd[k+1] = nbhd[k+2];
		end
		nbhd[2] = upper;
		nbhd[5] = middle;
		nbhd[8] = px;
		if (c >= 2 && r >= 2) begin
			made.median = window_median();
			made.column = ocol_t'(c - 1);
			made.row = orow_t'(r - 1);
			made.last = end_col && end_row;
			expected_medians.push_back(made);
		end
		if (end_col) begin
			col_pos = 0;
			row_pos = end_row ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	// Pixels still needed to close the current frame, the closing one included
	function automatic int unsigned pixels_to_frame_end();
		int unsigned c, r, n, w, h;
		c = col_pos;
		r = row_pos;
		n = 0;
		w = active_width();
		h = active_height();
		forever begin
			n++;
			if (c >= w - 1) begin
				if (r >= h - 1) return n;
				c = 0;
				r++;
			end else begin
				c++;
			end
		end
	endfunction

	// Mostly no gap, some short ones, a few long ones
	function automatic int unsigned pick_gap(bit calm);
		int unsigned roll;
		if (calm) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_pixel(pixel_t px);
		pixels_to_send.push_back(px);
		pixels_queued++;
	endtask

	// Uniform values, a narrow band above base (many ties), or only 0 and 255
	task automatic queue_pixels(int unsigned n, int unsigned style, pixel_t base);
		pixel_t px;
		repeat (n) begin
			case (style)
				STYLE_BAND:     px = base + pixel_t'($urandom_range(0, 3));
				STYLE_EXTREMES: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				default:        px = pixel_t'($urandom_range(0, 255));
			endcase
			send_pixel(px);
		end
	endtask

	// One APB transfer: setup cycle, then access until pready
	task automatic apb_transfer(logic [APB_ADDR_W-1:0] reg_idx, logic wr,
		logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= reg_idx << REG_SEL_BIT;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic verify_register(logic [APB_ADDR_W-1:0] reg_idx,
		logic [APB_DATA_W-1:0] want);
		logic [APB_DATA_W-1:0] got;
		apb_transfer(reg_idx, 1'b0, '0, got);
		if (got !== want) begin
			failures++;
			$display("%0t: register %0d read back: expected %0d, actual %0d",
				$time, reg_idx, want, got);
		end
	endtask

	// Write both size registers (bits above the field are ignored), then read them back
	task automatic set_frame(logic [APB_DATA_W-1:0] width_word,
		logic [APB_DATA_W-1:0] height_word);
		logic [APB_DATA_W-1:0] unused;
		apb_transfer(REG_FRAME_WIDTH, 1'b1, width_word, unused);
		frame_width_reg = fw_t'(width_word);
		apb_transfer(REG_FRAME_HEIGHT, 1'b1, height_word, unused);
		frame_height_reg = fh_t'(height_word);
		reg_writes += 2;
		verify_register(REG_FRAME_WIDTH, frame_width_reg);
		verify_register(REG_FRAME_HEIGHT, frame_height_reg);
	endtask

	// Hold until every pixel is in and every result is out, then let the pipeline settle
	task automatic wait_drained();
		while (pixels_accepted != pixels_queued || expected_medians.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Pixel driver: predict on accept, then offer the next item or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_bus.valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (pix_bus.valid && pix_bus.ready) begin
				slide_window(pix_bus.pixel);
				pixels_accepted++;
			end
			if (!pix_bus.valid || pix_bus.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					pix_bus.valid <= 1'b0;
				end else if (pixels_to_send.size() != 0) begin
					pix_bus.valid <= 1'b1;
					pix_bus.pixel <= pixels_to_send.pop_front();
					gap_left <= pick_gap(src_calm);
				end else begin
					pix_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare against the oldest expectation, then pick ready
	always @(posedge clk) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				got_result.median = res_bus.median;
				got_result.column = res_bus.out_column;
				got_result.row = res_bus.out_row;
				got_result.last = res_bus.frame_last;
				if (expected_medians.size() == 0) begin
					failures++;
					if (failures <= REPORT_CAP)
						$display("%0t: unexpected result: median %0d col %0d row %0d",
							$time, got_result.median, got_result.column, got_result.row,
							" last %0b", got_result.last);
				end else begin
					want_result = expected_medians.pop_front();
					results_checked++;
					if (want_result.last) frames_closed++;
					if (got_result.median !== want_result.median ||
						got_result.column !== want_result.column ||
						got_result.row !== want_result.row ||
						got_result.last !== want_result.last) begin
						failures++;
						if (failures <= REPORT_CAP)
							$display("%0t: mismatch: expected median %0d col %0d",
								$time, want_result.median, want_result.column,
								" row %0d last %0b,", want_result.row, want_result.last,
								" actual median %0d col %0d", got_result.median,
								got_result.column, " row %0d last %0b", got_result.row,
								got_result.last);
					end
				end
			end
			if (stall_left != 0) begin
				res_bus.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				res_bus.ready <= 1'b1;
				stall_left <= pick_gap(sink_calm);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned           n, roll, w_word, h_word, junk, style, random_items;
		pixel_t                base;
		// Drive every input to a known value before the first edge
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_bus.valid = 1'b0;
		pix_bus.pixel = '0;
		res_bus.ready = 1'b0;
		frame_width_reg = FW_RESET;
		frame_height_reg = FH_RESET;
		foreach (nbhd[i]) nbhd[i] = '0;
		col_pos = 0;
		row_pos = 0;
		random_items = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		verify_register(REG_FRAME_WIDTH, FW_RESET);
		verify_register(REG_FRAME_HEIGHT, FH_RESET);

		// Fill both line stores across the widest width used later; height clamps to three
		set_frame(FILL_WIDTH, 0);
		queue_pixels(pixels_to_frame_end(), STYLE_UNIFORM, 0);
		wait_drained();

		// Extremes of the pixel range
		src_calm = 1'b1;
		set_frame(5, 4);
		for (int i = 0; i < 20; i++) send_pixel(CORNER_FRAME[i]);
		wait_drained();

		// Tall narrow frame, width below the minimum clamps to three
		src_calm = 1'b0;
		set_frame(1, 60);
		queue_pixels(pixels_to_frame_end(), STYLE_UNIFORM, 0);
		wait_drained();

		// Smallest frame: one window, one result closing the frame
		set_frame(2, 1);
		for (int i = 0; i < 9; i++) send_pixel(LONE_WINDOW[i]);
		wait_drained();

		// Size changes in the middle of a frame: narrower, shorter, wider
		set_frame(8, 6);
		queue_pixels(8 * 3 + 5, STYLE_UNIFORM, 0);
		wait_drained();
		set_frame(4, 6);
		queue_pixels(pixels_to_frame_end(), STYLE_UNIFORM, 0);
		wait_drained();
		set_frame(6, 10);
		queue_pixels(6 * 5 + 2, STYLE_EXTREMES, 0);
		wait_drained();
		set_frame(6, 3);
		queue_pixels(pixels_to_frame_end(), STYLE_UNIFORM, 0);
		wait_drained();
		set_frame(6, 5);
		queue_pixels(6 * 2 + 1, STYLE_UNIFORM, 0);
		wait_drained();
		set_frame(10, 5);
		queue_pixels(pixels_to_frame_end(), STYLE_BAND, 8'd250);
		wait_drained();

		// Random phases: mostly whole frames, some cut short before a size change
		while (random_items < RANDOM_ITEMS) begin
			src_calm = ($urandom_range(0, 4) == 0);
			sink_calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) w_word = $urandom_range(0, 2);
				else if (roll < 85) w_word = $urandom_range(3, 12);
				else if (roll < 99) w_word = $urandom_range(13, 64);
				else w_word = $urandom_range(65, FILL_WIDTH);
				roll = $urandom_range(0, 99);
				if (w_word > 64) h_word = $urandom_range(0, 3);
				else if (roll < 8) h_word = $urandom_range(0, 2);
				else if (roll < 90) h_word = $urandom_range(3, 8);
				else h_word = $urandom_range(9, 40);
				junk = ($urandom_range(0, 3) == 0) ? $urandom() : 0;
				set_frame(w_word | (junk << FW_W), h_word | (junk << FH_W));
			end
			roll = $urandom_range(0, 99);
			style = (roll < 60) ? STYLE_UNIFORM : (roll < 80) ? STYLE_BAND : STYLE_EXTREMES;
			base = pixel_t'($urandom_range(0, 255));
			if ($urandom_range(0, 3) != 0)
				n = pixels_to_frame_end() + $urandom_range(0, 1) * active_width() * active_height();
			else
				n = $urandom_range(1, active_width() * active_height());
			// Keep the total close to the planned item count
			if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
			queue_pixels(n, style, base);
			random_items += n;
			wait_drained();
		end

		$display("Sent %0d pixels and checked %0d medians over %0d closed frames,",
			pixels_accepted, results_checked, frames_closed);
		$display("with %0d size register writes, clamped sizes and mid-frame size changes.",
			reg_writes);
		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
